@@ rtl/pbf_density_and_lambda_core_macros.svh @@
// Assertion macros shared by the fluid density core.
`ifndef PBF_DENSITY_AND_LAMBDA_CORE_MACROS_SVH
`define PBF_DENSITY_AND_LAMBDA_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pbf_pkg.sv @@
// ----------------------------------------------------------------------------
// pbf_pkg
// Types, constants and saturation helpers for the fluid density core.
// ----------------------------------------------------------------------------
package pbf_pkg;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic               neighbor_valid;
    logic               last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] density;
    logic signed [31:0] lambda_value;
  } out_item_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic               start;
    logic               raw;   // return the plain low 64 product bits
    logic               sh30;  // shift by 30 instead of 16
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef enum logic [2:0] {
    CFG_RADIUS = 3'd0,
    CFG_POLY6  = 3'd1,
    CFG_SPIKY  = 3'd2,
    CFG_INVRHO = 3'd3,
    CFG_SELF   = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RX, ST_RY, ST_RZ, ST_SQRT, ST_HH, ST_T1, ST_T2, ST_T3,
    ST_G1, ST_G2, ST_Q, ST_M, ST_S, ST_C, ST_F, ST_II, ST_DN, ST_DIV, ST_OUT
  } seq_state_t;

  localparam logic [31:0]        R_MIN     = 32'd16777;
  localparam logic signed [63:0] Q_ONE     = 64'sd65536;
  localparam logic [63:0]        EPS_Q     = 64'd327680;
  localparam logic [63:0]        MAG_CLAMP = 64'h4000_0000_0000_0000;
  localparam logic signed [63:0] S48_MAX   = 64'sd140737488355327;
  localparam logic signed [63:0] S48_MIN   = -64'sd140737488355328;
  localparam logic signed [63:0] S32_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN   = -64'sd2147483648;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > S48_MAX) r = S48_MAX[47:0];
    else if (v < S48_MIN) r = S48_MIN[47:0];
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = S32_MAX[31:0];
    else if (v < S32_MIN) r = S32_MIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] r;
    r = v[63] ? 64'(-v) : 64'(v);
    return r;
  endfunction

  function automatic logic signed [63:0] sx48(input logic signed [47:0] v);
    logic signed [63:0] r;
    r = {{16{v[47]}}, v};
    return r;
  endfunction

  function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
    logic signed [63:0] r;
    r = {{32{v[31]}}, v};
    return r;
  endfunction

endpackage

@@ rtl/pbf_density_and_lambda_core.sv @@
// Work: a valid neighbor inside the radius takes fifteen multiplies, a square root and
// three divisions; one closer than 0.001 and one outside the radius stop earlier, and an
// empty item is dropped at once.
// A last item adds lambda (6 multiplies, one division), then waits out any out_ready stall.
// One item at a time; the input is not ready while an item is in work.
// Reset (synchronous, rst_n low) loads register defaults and clears all sums.
// ----------------------------------------------------------------------------
// pbf_density_and_lambda_core
// Per-particle density and constraint multiplier, built from a sequencer
// driving a shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
`include "pbf_density_and_lambda_core_macros.svh"

module pbf_density_and_lambda_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbf_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);

  // Configuration
  logic [30:0]        h_r, inv_r, self_r;
  logic signed [31:0] p6_r, spk_r;

  // Item and sums
  logic signed [31:0] ex_r, ey_r, ez_r, ex_nxt, ey_nxt, ez_nxt;
  logic               last_r, last_nxt;
  logic signed [47:0] dsum_r, gxs_r, gys_r, gzs_r, gsq_r;
  logic signed [47:0] dsum_nxt, gxs_nxt, gys_nxt, gzs_nxt, gsq_nxt;

  // Work registers
  logic [63:0]        r2_r, r2_nxt, den_r, den_nxt;
  logic [31:0]        root_r, root_nxt, d_r, d_nxt;
  logic signed [63:0] t_r, t_nxt, g_r, g_nxt, q_r, q_nxt;
  logic signed [47:0] gcur_r, gcur_nxt, c_r, c_nxt, ss_r, ss_nxt;
  logic signed [31:0] dens_r, dens_nxt, lam_r, lam_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  pbf_pkg::out_item_t out_data_r, out_data_nxt;
  pbf_pkg::seq_state_t state_r, state_nxt;

  // Unit hookup
  pbf_pkg::mul_req_t  mul_req;
  logic               mul_busy, mul_done;
  logic signed [63:0] mul_res;
  logic               sqrt_start, sqrt_done;
  logic [31:0]        sqrt_root;
  logic               div_start, div_done;
  logic [63:0]        div_num, div_den, div_quot;

  logic               step_start;
  logic signed [31:0] e_axis;
  logic signed [47:0] gs_axis;
  logic [63:0]        e_mag;
  logic signed [31:0] dens_now;
  logic signed [63:0] hr_v;
  logic [63:0]        qmag;

  pbf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .req(mul_req),
    .busy(mul_busy), .done(mul_done), .result(mul_res)
  );

  pbf_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start),
    .radicand(r2_r), .done(sqrt_done), .root(sqrt_root)
  );

  pbf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(div_den), .done(div_done), .quot(div_quot)
  );

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= 31'd16777216;
      p6_r   <= 32'sd65536;
      spk_r  <= -32'sd65536;
      inv_r  <= 31'd65536;
      self_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        pbf_pkg::CFG_RADIUS: h_r    <= cfg_wdata[30:0];
        pbf_pkg::CFG_POLY6:  p6_r   <= cfg_wdata;
        pbf_pkg::CFG_SPIKY:  spk_r  <= cfg_wdata;
        pbf_pkg::CFG_INVRHO: inv_r  <= cfg_wdata[30:0];
        pbf_pkg::CFG_SELF:   self_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Per-axis selection
  always_comb begin
    case (axis_r)
      2'd0: begin e_axis = ex_r; gs_axis = gxs_r; end
      2'd1: begin e_axis = ey_r; gs_axis = gys_r; end
      default: begin e_axis = ez_r; gs_axis = gzs_r; end
    endcase
  end

  assign e_mag    = pbf_pkg::mag64(pbf_pkg::sx32(e_axis));
  assign dens_now = pbf_pkg::sat32($signed({33'd0, self_r}) + pbf_pkg::sx48(dsum_r));
  assign hr_v     = $signed({41'd0, 23'((32'(h_r) - root_r) >> 8)});
  assign qmag     = pbf_pkg::mag64(pbf_pkg::sx48(c_r)) << 16;
  assign step_start = !pend_r;
  assign in_ready = (state_r == pbf_pkg::ST_IDLE);

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt = state_r;
    ex_nxt = ex_r; ey_nxt = ey_r; ez_nxt = ez_r; last_nxt = last_r;
    dsum_nxt = dsum_r; gxs_nxt = gxs_r; gys_nxt = gys_r; gzs_nxt = gzs_r;
    gsq_nxt = gsq_r;
    r2_nxt = r2_r; den_nxt = den_r; root_nxt = root_r; d_nxt = d_r;
    t_nxt = t_r; g_nxt = g_r; q_nxt = q_r; gcur_nxt = gcur_r;
    c_nxt = c_r; ss_nxt = ss_r; dens_nxt = dens_r; lam_nxt = lam_r;
    axis_nxt = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    mul_req = '0;
    sqrt_start = 1'b0;
    div_start = 1'b0;
    div_num = {31'd0, e_mag[32:0]} << 30;
    div_den = {32'd0, root_r};

    case (state_r)
      pbf_pkg::ST_IDLE: begin
        if (in_valid) begin
          ex_nxt = in_data.offset_x;
          ey_nxt = in_data.offset_y;
          ez_nxt = in_data.offset_z;
          last_nxt = in_data.last_neighbor;
          if (in_data.neighbor_valid) state_nxt = pbf_pkg::ST_RX;
          else if (in_data.last_neighbor) state_nxt = pbf_pkg::ST_C;
        end
      end
      // Squared distance
      pbf_pkg::ST_RX, pbf_pkg::ST_RY, pbf_pkg::ST_RZ: begin
        mul_req.start = step_start;
        mul_req.raw = 1'b1;
        case (state_r)
          pbf_pkg::ST_RX: mul_req.a = pbf_pkg::sx32(ex_r);
          pbf_pkg::ST_RY: mul_req.a = pbf_pkg::sx32(ey_r);
          default: mul_req.a = pbf_pkg::sx32(ez_r);
        endcase
        mul_req.b = mul_req.a;
        if (mul_done) begin
          case (state_r)
            pbf_pkg::ST_RX: begin r2_nxt = mul_res; state_nxt = pbf_pkg::ST_RY; end
            pbf_pkg::ST_RY: begin r2_nxt = r2_r + mul_res; state_nxt = pbf_pkg::ST_RZ; end
            default: begin r2_nxt = r2_r + mul_res; state_nxt = pbf_pkg::ST_SQRT; end
          endcase
        end
      end
      pbf_pkg::ST_SQRT: begin
        sqrt_start = step_start;
        if (sqrt_done) begin
          root_nxt = sqrt_root;
          if (sqrt_root < 32'(h_r)) state_nxt = pbf_pkg::ST_HH;
          else state_nxt = last_r ? pbf_pkg::ST_C : pbf_pkg::ST_IDLE;
        end
      end
      pbf_pkg::ST_HH: begin
        mul_req.start = step_start;
        mul_req.raw = 1'b1;
        mul_req.a = $signed({33'd0, h_r});
        mul_req.b = $signed({33'd0, h_r});
        if (mul_done) begin
          d_nxt = 32'((64'(mul_res) - r2_r) >> 32);
          state_nxt = pbf_pkg::ST_T1;
        end
      end
      // Poly6 term
      pbf_pkg::ST_T1, pbf_pkg::ST_T2, pbf_pkg::ST_T3: begin
        mul_req.start = step_start;
        case (state_r)
          pbf_pkg::ST_T1: begin
            mul_req.a = $signed({32'd0, d_r}); mul_req.b = $signed({32'd0, d_r});
          end
          pbf_pkg::ST_T2: begin
            mul_req.a = t_r; mul_req.b = $signed({32'd0, d_r});
          end
          default: begin
            mul_req.a = pbf_pkg::sx32(p6_r); mul_req.b = t_r;
          end
        endcase
        if (mul_done) begin
          t_nxt = mul_res;
          case (state_r)
            pbf_pkg::ST_T1: state_nxt = pbf_pkg::ST_T2;
            pbf_pkg::ST_T2: state_nxt = pbf_pkg::ST_T3;
            default: begin
              dsum_nxt = pbf_pkg::sat48(pbf_pkg::sx48(dsum_r) +
                                        pbf_pkg::sx48(pbf_pkg::sat48(mul_res)));
              if (root_r >= pbf_pkg::R_MIN) state_nxt = pbf_pkg::ST_G1;
              else state_nxt = last_r ? pbf_pkg::ST_C : pbf_pkg::ST_IDLE;
            end
          endcase
        end
      end
      // Spiky magnitude
      pbf_pkg::ST_G1: begin
        mul_req.start = step_start;
        mul_req.a = hr_v;
        mul_req.b = hr_v;
        if (mul_done) begin
          t_nxt = mul_res;
          state_nxt = pbf_pkg::ST_G2;
        end
      end
      pbf_pkg::ST_G2: begin
        mul_req.start = step_start;
        mul_req.a = pbf_pkg::sx32(spk_r);
        mul_req.b = t_r;
        if (mul_done) begin
          g_nxt = mul_res;
          axis_nxt = 2'd0;
          state_nxt = pbf_pkg::ST_Q;
        end
      end
      // Direction ratio for the current axis
      pbf_pkg::ST_Q: begin
        div_start = step_start;
        if (div_done) begin
          q_nxt = e_axis[31] ? -$signed(div_quot) : $signed(div_quot);
          state_nxt = pbf_pkg::ST_M;
        end
      end
      pbf_pkg::ST_M: begin
        mul_req.start = step_start;
        mul_req.sh30 = 1'b1;
        mul_req.a = g_r;
        mul_req.b = q_r;
        if (mul_done) begin
          gcur_nxt = pbf_pkg::sat48(mul_res);
          case (axis_r)
            2'd0: gxs_nxt = pbf_pkg::sat48(pbf_pkg::sx48(gxs_r) +
                                           pbf_pkg::sx48(pbf_pkg::sat48(mul_res)));
            2'd1: gys_nxt = pbf_pkg::sat48(pbf_pkg::sx48(gys_r) +
                                           pbf_pkg::sx48(pbf_pkg::sat48(mul_res)));
            default: gzs_nxt = pbf_pkg::sat48(pbf_pkg::sx48(gzs_r) +
                                              pbf_pkg::sx48(pbf_pkg::sat48(mul_res)));
          endcase
          state_nxt = pbf_pkg::ST_S;
        end
      end
      pbf_pkg::ST_S: begin
        mul_req.start = step_start;
        mul_req.a = pbf_pkg::sx48(gcur_r);
        mul_req.b = pbf_pkg::sx48(gcur_r);
        if (mul_done) begin
          gsq_nxt = pbf_pkg::sat48(pbf_pkg::sx48(gsq_r) + mul_res);
          if (axis_r == 2'd2) state_nxt = last_r ? pbf_pkg::ST_C : pbf_pkg::ST_IDLE;
          else begin
            axis_nxt = axis_r + 2'd1;
            state_nxt = pbf_pkg::ST_Q;
          end
        end
      end
      // Constraint value
      pbf_pkg::ST_C: begin
        mul_req.start = step_start;
        mul_req.a = pbf_pkg::sx32(dens_now);
        mul_req.b = $signed({33'd0, inv_r});
        if (mul_done) begin
          dens_nxt = dens_now;
          c_nxt = pbf_pkg::sat48(mul_res - pbf_pkg::Q_ONE);
          ss_nxt = gsq_r;
          axis_nxt = 2'd0;
          state_nxt = pbf_pkg::ST_F;
        end
      end
      // Gradient norm sum
      pbf_pkg::ST_F: begin
        mul_req.start = step_start;
        mul_req.a = pbf_pkg::sx48(gs_axis);
        mul_req.b = pbf_pkg::sx48(gs_axis);
        if (mul_done) begin
          ss_nxt = pbf_pkg::sat48(pbf_pkg::sx48(ss_r) + mul_res);
          if (axis_r == 2'd2) state_nxt = pbf_pkg::ST_II;
          else axis_nxt = axis_r + 2'd1;
        end
      end
      pbf_pkg::ST_II: begin
        mul_req.start = step_start;
        mul_req.a = $signed({33'd0, inv_r});
        mul_req.b = $signed({33'd0, inv_r});
        if (mul_done) begin
          t_nxt = mul_res;
          state_nxt = pbf_pkg::ST_DN;
        end
      end
      pbf_pkg::ST_DN: begin
        mul_req.start = step_start;
        mul_req.a = pbf_pkg::sx48(ss_r);
        mul_req.b = t_r;
        if (mul_done) begin
          den_nxt = 64'(mul_res) + pbf_pkg::EPS_Q;
          state_nxt = pbf_pkg::ST_DIV;
        end
      end
      pbf_pkg::ST_DIV: begin
        div_start = step_start;
        div_num = qmag;
        div_den = den_r;
        if (div_done) begin
          lam_nxt = pbf_pkg::sat32((c_r > 48'sd0) ? -$signed(div_quot)
                                                 : $signed(div_quot));
          state_nxt = pbf_pkg::ST_OUT;
        end
      end
      // Hand off the result and clear the sums
      pbf_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.density = dens_r;
          out_data_nxt.lambda_value = lam_r;
          dsum_nxt = '0; gxs_nxt = '0; gys_nxt = '0; gzs_nxt = '0; gsq_nxt = '0;
          state_nxt = pbf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pbf_pkg::ST_IDLE;
    endcase

    // Track an outstanding unit operation
    pend_nxt = pend_r;
    if (mul_req.start || sqrt_start || div_start) pend_nxt = 1'b1;
    if (mul_done || sqrt_done || div_done) pend_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbf_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      axis_r      <= 2'd0;
      dsum_r <= '0; gxs_r <= '0; gys_r <= '0; gzs_r <= '0; gsq_r <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r      <= axis_nxt;
      dsum_r <= dsum_nxt; gxs_r <= gxs_nxt; gys_r <= gys_nxt;
      gzs_r <= gzs_nxt; gsq_r <= gsq_nxt;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk) begin
    ex_r <= ex_nxt; ey_r <= ey_nxt; ez_r <= ez_nxt; last_r <= last_nxt;
    r2_r <= r2_nxt; den_r <= den_nxt; root_r <= root_nxt; d_r <= d_nxt;
    t_r <= t_nxt; g_r <= g_nxt; q_r <= q_nxt; gcur_r <= gcur_nxt;
    c_r <= c_nxt; ss_r <= ss_nxt; dens_r <= dens_nxt; lam_r <= lam_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PBF_ASSERT_NOW(a_mul_free, mul_req.start, !mul_busy, "multiplier started while busy")
  `PBF_ASSERT_NOW(a_div_den, div_start, div_den != 64'd0, "division by zero issued")
  `PBF_ASSERT_NEXT(a_empty_item, in_valid && in_ready && !in_data.neighbor_valid && !in_data.last_neighbor, state_r == pbf_pkg::ST_IDLE, "empty item not dropped at once")
  `PBF_ASSERT_NOW(a_out_src, $rose(out_valid_r), $past(state_r == pbf_pkg::ST_OUT), "result raised outside hand-off")

endmodule

@@ rtl/pbf_mul.sv @@
// ----------------------------------------------------------------------------
// pbf_mul
// Shared 64x64 magnitude multiplier: four 32x32 partial products, one per cycle,
// then shift by 16 or 30, clamp at 2^62 and restore the sign; raw mode returns the low 64 bits.
// ----------------------------------------------------------------------------
module pbf_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  pbf_pkg::mul_req_t  req,
  output logic               busy,
  output logic               done,
  output logic signed [63:0] result
);

  logic [63:0]        ua_r, ub_r;
  logic               neg_r, raw_r, sh30_r;
  logic [127:0]       acc_r;
  logic [2:0]         cnt_r;
  logic               busy_r, done_r;
  logic signed [63:0] res_r;

  logic [31:0]  op_a, op_b;
  logic [63:0]  pp;
  logic [127:0] pp_al;
  logic [127:0] shv;
  logic         ovf;
  logic [63:0]  magv;

  // Pick the partial product for this cycle
  always_comb begin
    case (cnt_r)
      3'd0: begin op_a = ua_r[31:0];  op_b = ub_r[31:0];  end
      3'd1: begin op_a = ua_r[31:0];  op_b = ub_r[63:32]; end
      3'd2: begin op_a = ua_r[63:32]; op_b = ub_r[31:0];  end
      default: begin op_a = ua_r[63:32]; op_b = ub_r[63:32]; end
    endcase
    pp = op_a * op_b;
    case (cnt_r)
      3'd0: pp_al = {64'd0, pp};
      3'd1, 3'd2: pp_al = {32'd0, pp, 32'd0};
      default: pp_al = {pp, 64'd0};
    endcase
  end

  // Shift, clamp and sign the final product
  always_comb begin
    shv  = sh30_r ? (acc_r >> 30) : (acc_r >> 16);
    ovf  = (|shv[127:63]) || (shv[62] && (|shv[61:0]));
    magv = ovf ? pbf_pkg::MAG_CLAMP : shv[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
        acc_r  <= 128'd0;
        ua_r   <= pbf_pkg::mag64(req.a);
        ub_r   <= pbf_pkg::mag64(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        raw_r  <= req.raw;
        sh30_r <= req.sh30;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (raw_r) res_r <= acc_r[63:0];
          else res_r <= neg_r ? -$signed(magv) : $signed(magv);
        end else begin
          acc_r <= acc_r + pp_al;
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = res_r;

endmodule

@@ rtl/pbf_sqrt.sv @@
// ----------------------------------------------------------------------------
// pbf_sqrt
// Bit-pair integer square root of a 64-bit value, one step per cycle.
// ----------------------------------------------------------------------------
module pbf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n_r, res_r, bit_r;
  logic        busy_r, done_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r    <= radicand;
        res_r  <= 64'd0;
        bit_r  <= 64'h4000_0000_0000_0000;
      end else if (busy_r) begin
        // One result bit per step
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

@@ rtl/pbf_div.sv @@
// ----------------------------------------------------------------------------
// pbf_div
// Restoring 64-by-64 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic [64:0] rem_r;
  logic [63:0] q_r, den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] rem_sh;
  logic        fit;

  assign rem_sh = {rem_r[63:0], q_r[63]};
  assign fit    = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= 65'd0;
        q_r    <= num;
        den_r  <= den;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        // Shift in the next dividend bit, subtract when it fits
        rem_r <= fit ? (rem_sh - {1'b0, den_r}) : rem_sh;
        q_r   <= {q_r[62:0], fit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
